// ===== hw/rtl/masked_normalized_cross_correlation_macros.svh =====
// assertion macros for the correlation block checker
`ifndef MASKED_NORMALIZED_CROSS_CORRELATION_MACROS_SVH
`define MASKED_NORMALIZED_CROSS_CORRELATION_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MNCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MNCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mncc_pkg.sv =====
// shared constants, types and width helpers for the correlation block
`default_nettype none

package mncc_pkg;

	localparam int SAMPLE_BITS_DEF      = 16;
	localparam int VOXEL_COUNT_LOG2_DEF = 24;
	localparam int ACC_CAP              = 62;
	localparam int CORR_BITS            = 16;
	localparam int ROOT_BITS            = 16;
	localparam int QUO_BITS             = 32;

	localparam logic [CORR_BITS-1:0] SAT_MAG = 16'h8000;
	localparam logic [CORR_BITS-1:0] POS_MAX = 16'h7fff;

	typedef struct packed {
		logic start;
		logic take;
	} unit_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic int e_bits(input int sb, input int vl);
		int raw;
		raw = 2 * sb - 1 + vl;
		return (raw > ACC_CAP) ? ACC_CAP : raw;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mncc_in_if.sv =====
// voxel pair channel: valid, ready and the voxel payload
`default_nettype none

interface mncc_in_if #(
	parameter int SAMPLE_BITS = mncc_pkg::SAMPLE_BITS_DEF
) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_a;
	logic signed [SAMPLE_BITS-1:0] sample_b;
	logic                          in_mask;
	logic                          last_voxel;

	modport source (output valid, sample_a, sample_b, in_mask, last_voxel, input ready);
	modport sink   (input valid, sample_a, sample_b, in_mask, last_voxel, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/mncc_out_if.sv =====
// result channel: valid, ready and the correlation payload
`default_nettype none

interface mncc_out_if ();

	logic                                   valid;
	logic                                   ready;
	logic signed [mncc_pkg::CORR_BITS-1:0] correlation;
	logic                                   zero_energy;

	modport source (output valid, correlation, zero_energy, input ready);
	modport sink   (input valid, correlation, zero_energy, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/mncc_accum.sv =====
// cross and energy accumulators fed by one shared sample multiplier
`default_nettype none

module mncc_accum #(
	parameter int SAMPLE_BITS      = mncc_pkg::SAMPLE_BITS_DEF,
	parameter int VOXEL_COUNT_LOG2 = mncc_pkg::VOXEL_COUNT_LOG2_DEF,
	localparam int E_BITS = mncc_pkg::e_bits(SAMPLE_BITS, VOXEL_COUNT_LOG2),
	localparam int C_BITS = E_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mncc_pkg::unit_ctrl_t          ctrl,
	output mncc_pkg::unit_stat_t          stat,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	output logic [C_BITS-1:0]             cross_sum,
	output logic [E_BITS-1:0]             energy_first,
	output logic [E_BITS-1:0]             energy_second
);

	localparam int PROD_BITS = 2 * SAMPLE_BITS;

	localparam logic [1:0] STEP_AB  = 2'd0;
	localparam logic [1:0] STEP_AA  = 2'd1;
	localparam logic [1:0] STEP_BB  = 2'd2;
	localparam logic [1:0] STEP_END = 2'd3;

	logic                          run_q;
	logic                          done_q;
	logic [1:0]                    cnt_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] b_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic [C_BITS-1:0]             cross_q;
	logic [E_BITS-1:0]             ef_q;
	logic [E_BITS-1:0]             es_q;
	logic signed [SAMPLE_BITS-1:0] mul_x;
	logic signed [SAMPLE_BITS-1:0] mul_y;
	logic [C_BITS-1:0]             add_a;
	logic [C_BITS-1:0]             add_b;
	logic [C_BITS-1:0]             add_sum;

	// product order: a*b, a*a, b*b; each is registered in prod_q and added in the next cycle
	always_comb begin
		mul_x = (cnt_q == STEP_BB) ? b_q : a_q;
		mul_y = (cnt_q == STEP_AA) ? a_q : b_q;
		add_b = {{(C_BITS - PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
		unique case (cnt_q)
			STEP_AA:  add_a = cross_q;
			STEP_BB:  add_a = C_BITS'(ef_q);
			STEP_END: add_a = C_BITS'(es_q);
			default:  add_a = '0;
		endcase
		add_sum = add_a + add_b;
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= sample_a;
			b_q <= sample_b;
		end
		prod_q <= mul_x * mul_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= STEP_AB;
			cross_q <= '0;
			ef_q    <= '0;
			es_q    <= '0;
		end else begin
			done_q <= run_q && (cnt_q == STEP_END);
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_AB;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == STEP_END) begin
					run_q <= 1'b0;
				end
			end
			if (ctrl.take) begin
				cross_q <= '0;
				ef_q    <= '0;
				es_q    <= '0;
			end else if (run_q) begin
				unique case (cnt_q)
					STEP_AA:  cross_q <= add_sum;
					STEP_BB:  ef_q    <= add_sum[E_BITS-1:0];
					STEP_END: es_q    <= add_sum[E_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	assign stat.busy     = run_q;
	assign stat.done     = done_q;
	assign cross_sum     = cross_q;
	assign energy_first  = ef_q;
	assign energy_second = es_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mncc_norm.sv =====
// normalization sequencer around one shared wide add/subtract unit
`default_nettype none

module mncc_norm #(
	parameter int SAMPLE_BITS      = mncc_pkg::SAMPLE_BITS_DEF,
	parameter int VOXEL_COUNT_LOG2 = mncc_pkg::VOXEL_COUNT_LOG2_DEF,
	localparam int E_BITS = mncc_pkg::e_bits(SAMPLE_BITS, VOXEL_COUNT_LOG2),
	localparam int C_BITS = E_BITS + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mncc_pkg::unit_ctrl_t                  ctrl,
	output mncc_pkg::unit_stat_t                  stat,
	input  logic [C_BITS-1:0]                     cross_sum,
	input  logic [E_BITS-1:0]                     energy_first,
	input  logic [E_BITS-1:0]                     energy_second,
	output logic signed [mncc_pkg::CORR_BITS-1:0] correlation,
	output logic                                  zero_energy
);

	localparam int W        = 2 * C_BITS;
	localparam int QUO      = mncc_pkg::QUO_BITS;
	localparam int ROOT     = mncc_pkg::ROOT_BITS;
	localparam int CB       = mncc_pkg::CORR_BITS;
	localparam int CNT_SPAN = (C_BITS > QUO) ? C_BITS : QUO;
	localparam int CNT_W    = $clog2(CNT_SPAN);

	localparam logic [CNT_W-1:0] LAST_MUL  = CNT_W'(C_BITS - 1);
	localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(QUO - 1);
	localparam logic [CNT_W-1:0] LAST_ROOT = CNT_W'(ROOT - 1);

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_PREP = 3'd1;
	localparam logic [2:0] N_SQM  = 3'd2;
	localparam logic [2:0] N_MULP = 3'd3;
	localparam logic [2:0] N_CMP  = 3'd4;
	localparam logic [2:0] N_DIV  = 3'd5;
	localparam logic [2:0] N_ROOT = 3'd6;
	localparam logic [2:0] N_DONE = 3'd7;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              zero_q;
	logic              sat_q;
	logic              neg_q;
	logic [W-1:0]      x_q;
	logic [W-1:0]      p_q;
	logic [W-1:0]      y_q;
	logic [W-1:0]      m_q;
	logic [C_BITS-1:0] n_q;
	logic [QUO-1:0]    q_q;
	logic [ROOT-1:0]   root_q;

	logic [W-1:0]      alu_a;
	logic [W-1:0]      alu_b;
	logic              alu_sub;
	logic [W:0]        alu_sum;
	logic              alu_ge;
	logic [W-1:0]      alu_res;
	logic [W-1:0]      next_y;
	logic [C_BITS-1:0] mag;
	logic              zero_hit;
	logic [CB-1:0]     mag16;
	logic [CB-1:0]     corr_bits;

	// operand select for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			N_PREP: begin
				alu_b   = W'(cross_sum);
				alu_sub = 1'b1;
			end
			N_SQM, N_MULP: begin
				alu_a = y_q;
				alu_b = m_q;
			end
			N_CMP: begin
				alu_a   = x_q;
				alu_b   = p_q;
				alu_sub = 1'b1;
			end
			N_DIV: begin
				alu_a   = {y_q[W-2:0], 1'b0};
				alu_b   = p_q;
				alu_sub = 1'b1;
			end
			N_ROOT: begin
				alu_a   = {y_q[W-3:0], q_q[QUO-1:QUO-2]};
				alu_b   = W'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			default: ;
		endcase
		alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W + 1)'(alu_sub);
	end

	assign alu_ge   = alu_sum[W];
	assign alu_res  = alu_sum[W-1:0];
	assign next_y   = n_q[0] ? alu_res : y_q;
	assign mag      = cross_sum[C_BITS-1] ? alu_res[C_BITS-1:0] : cross_sum;
	assign zero_hit = (energy_first == '0) || (energy_second == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
			sat_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (ctrl.start) begin
						state_q <= N_PREP;
					end
				end
				N_PREP: begin
					cnt_q   <= '0;
					zero_q  <= zero_hit;
					sat_q   <= 1'b0;
					neg_q   <= cross_sum[C_BITS-1];
					state_q <= zero_hit ? N_DONE : N_SQM;
				end
				N_SQM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_MUL) begin
						cnt_q   <= '0;
						state_q <= N_MULP;
					end
				end
				N_MULP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_MUL) begin
						cnt_q   <= '0;
						state_q <= N_CMP;
					end
				end
				N_CMP: begin
					cnt_q <= '0;
					if (alu_ge) begin
						sat_q   <= 1'b1;
						state_q <= N_DONE;
					end else begin
						state_q <= N_DIV;
					end
				end
				N_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_DIV) begin
						cnt_q   <= '0;
						state_q <= N_ROOT;
					end
				end
				N_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ROOT) begin
						cnt_q   <= '0;
						state_q <= N_DONE;
					end
				end
				N_DONE: begin
					if (ctrl.take) begin
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// square of magnitude, energy product, quotient, then integer root
	always_ff @(posedge clk) begin
		unique case (state_q)
			N_PREP: begin
				m_q <= W'(mag);
				n_q <= mag;
				y_q <= '0;
			end
			N_SQM: begin
				y_q <= next_y;
				m_q <= m_q << 1;
				n_q <= n_q >> 1;
				if (cnt_q == LAST_MUL) begin
					x_q <= next_y;
					y_q <= '0;
					m_q <= W'(energy_first);
					n_q <= C_BITS'(energy_second);
				end
			end
			N_MULP: begin
				y_q <= next_y;
				m_q <= m_q << 1;
				n_q <= n_q >> 1;
				if (cnt_q == LAST_MUL) begin
					p_q <= next_y;
				end
			end
			N_CMP: y_q <= x_q;
			N_DIV: begin
				y_q <= alu_ge ? alu_res : alu_a;
				q_q <= {q_q[QUO-2:0], alu_ge};
				if (cnt_q == LAST_DIV) begin
					y_q    <= '0;
					root_q <= '0;
				end
			end
			N_ROOT: begin
				y_q    <= alu_ge ? alu_res : alu_a;
				root_q <= {root_q[ROOT-2:0], alu_ge};
				q_q    <= q_q << 2;
			end
			default: ;
		endcase
	end

	// odd root rounds the halved root up
	always_comb begin
		if (sat_q) begin
			mag16 = mncc_pkg::SAT_MAG;
		end else begin
			mag16 = CB'({1'b0, root_q[ROOT-1:1]}) + CB'(root_q[0]);
		end
		priority if (zero_q) begin
			corr_bits = '0;
		end else if (neg_q) begin
			corr_bits = ~mag16 + 1'b1;
		end else if (mag16[CB-1]) begin
			corr_bits = mncc_pkg::POS_MAX;
		end else begin
			corr_bits = mag16;
		end
	end

	assign correlation = signed'(corr_bits);
	assign zero_energy = zero_q;
	assign stat.busy   = (state_q != N_IDLE);
	assign stat.done   = (state_q == N_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/masked_normalized_cross_correlation.sv =====
// top level: masked uncentered normalized cross correlation of two voxel streams
//
// channel  dir  handshake    payload
// voxel    in   valid/ready  sample_a, sample_b, in_mask, last_voxel
// result   out  valid/ready  correlation, zero_energy
//
// item without mask or last mark: taken with no stall, ready stays high
// masked item: input stalls until the accumulators are through with it, one multiplier shared by the three products
// last item: the work runs on the shared 2*C-bit add/subtract unit (C = cross width):
//   two shift-add multiplies, 32 divide, 16 root steps; zero energy skips them all,
//   saturation skips divide and root; a last item also waits while an earlier
//   result is unread
// asynchronous reset clears the control state and the accumulators
// result sits in an output register; items keep flowing while it waits for ready
`default_nettype none

module masked_normalized_cross_correlation #(
	parameter int SAMPLE_BITS      = mncc_pkg::SAMPLE_BITS_DEF,
	parameter int VOXEL_COUNT_LOG2 = mncc_pkg::VOXEL_COUNT_LOG2_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mncc_in_if.sink    voxel,
	mncc_out_if.source result
);

	localparam int E_BITS = mncc_pkg::e_bits(SAMPLE_BITS, VOXEL_COUNT_LOG2);
	localparam int C_BITS = E_BITS + 1;
	localparam int CB     = mncc_pkg::CORR_BITS;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_ACC  = 2'd1;
	localparam logic [1:0] T_NORM = 2'd2;

	logic [1:0]              state_q;
	logic                    last_q;
	logic                    accept;
	logic                    norm_take;
	mncc_pkg::unit_ctrl_t    acc_ctrl;
	mncc_pkg::unit_ctrl_t    norm_ctrl;
	mncc_pkg::unit_stat_t    acc_stat;
	mncc_pkg::unit_stat_t    norm_stat;
	logic [C_BITS-1:0]       cross_sum;
	logic [E_BITS-1:0]       energy_first;
	logic [E_BITS-1:0]       energy_second;
	logic signed [CB-1:0]    norm_corr;
	logic                    norm_zero;
	logic                    out_valid_q;
	logic signed [CB-1:0]    corr_q;
	logic                    zero_q;

	assign voxel.ready = (state_q == T_IDLE) && !acc_stat.busy && !norm_stat.busy;
	assign accept      = voxel.valid && voxel.ready;
	assign norm_take   = (state_q == T_NORM) && norm_stat.done && (!out_valid_q || result.ready);

	assign acc_ctrl.start  = accept && voxel.in_mask;
	assign acc_ctrl.take   = norm_take;
	assign norm_ctrl.start = (accept && !voxel.in_mask && voxel.last_voxel)
		|| ((state_q == T_ACC) && acc_stat.done && last_q);
	assign norm_ctrl.take  = norm_take;

	mncc_accum #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.VOXEL_COUNT_LOG2 (VOXEL_COUNT_LOG2)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (acc_ctrl),
		.stat          (acc_stat),
		.sample_a      (voxel.sample_a),
		.sample_b      (voxel.sample_b),
		.cross_sum     (cross_sum),
		.energy_first  (energy_first),
		.energy_second (energy_second)
	);

	mncc_norm #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.VOXEL_COUNT_LOG2 (VOXEL_COUNT_LOG2)
	) u_norm (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (norm_ctrl),
		.stat          (norm_stat),
		.cross_sum     (cross_sum),
		.energy_first  (energy_first),
		.energy_second (energy_second),
		.correlation   (norm_corr),
		.zero_energy   (norm_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						last_q <= voxel.last_voxel;
						if (voxel.in_mask) begin
							state_q <= T_ACC;
						end else if (voxel.last_voxel) begin
							state_q <= T_NORM;
						end
					end
				end
				T_ACC: begin
					if (acc_stat.done) begin
						state_q <= last_q ? T_NORM : T_IDLE;
					end
				end
				T_NORM: begin
					if (norm_take) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (norm_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (norm_take) begin
			corr_q <= norm_corr;
			zero_q <= norm_zero;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.correlation = corr_q;
	assign result.zero_energy = zero_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mncc_checker.sv =====
// port-level checker for the correlation block and its bind
`default_nettype none

`include "masked_normalized_cross_correlation_macros.svh"

module mncc_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  in_mask,
	input wire logic                                  last_voxel,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [mncc_pkg::CORR_BITS-1:0] correlation,
	input wire logic                                  zero_energy
);

	`MNCC_ASSERT_NOW(a_zero_corr, out_valid && zero_energy, correlation == '0, "zero energy result with nonzero correlation")
	`MNCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(correlation) && $stable(zero_energy), "result changed while stalled")
	`MNCC_ASSERT_NEXT(a_busy_after, in_valid && in_ready && (in_mask || last_voxel), !in_ready, "ready while an item is at work")
	`MNCC_ASSERT_NEXT(a_skip_fast, in_valid && in_ready && !in_mask && !last_voxel, in_ready, "unmasked item stalled the input")

endmodule

bind masked_normalized_cross_correlation mncc_checker u_mncc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (voxel.valid),
	.in_ready    (voxel.ready),
	.in_mask     (voxel.in_mask),
	.last_voxel  (voxel.last_voxel),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.correlation (result.correlation),
	.zero_energy (result.zero_energy)
);

`default_nettype wire

// ===== dv/masked_normalized_cross_correlation_test.sv =====
// self-checking bench for the masked normalized cross correlation block
`timescale 1ns / 100ps

module masked_normalized_cross_correlation_test;

	localparam int SAMPLE_W   = mncc_pkg::SAMPLE_BITS_DEF;
	localparam int ENERGY_W   = mncc_pkg::e_bits(mncc_pkg::SAMPLE_BITS_DEF,
		mncc_pkg::VOXEL_COUNT_LOG2_DEF);
	localparam int CROSS_W    = ENERGY_W + 1;
	localparam int CORR_W     = mncc_pkg::CORR_BITS;
	localparam int VOXEL_GOAL = 550;
	localparam int DRAIN_WAIT = 400;
	localparam int ROWS       = 25;

	typedef struct packed {
		logic signed [CORR_W-1:0] correlation;
		logic                     zero_energy;
	} corr_result_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_a;
		logic signed [SAMPLE_W-1:0] sample_b;
		logic                       in_mask;
		logic                       last_voxel;
	} voxel_t;

	typedef struct packed {
		logic         typed;
		corr_result_t want;
	} voxel_note_t;

	typedef struct packed {
		voxel_t       voxel;
		logic         typed;
		corr_result_t want;
	} directed_row_t;

	typedef enum int {
		STYLE_FULL,
		STYLE_SMALL,
		STYLE_NOISY,
		STYLE_MIRROR,
		STYLE_EXTREME
	} volume_style_t;

	logic clk;
	logic arst_n;

	mncc_in_if  voxel_ch ();
	mncc_out_if result_ch ();

	masked_normalized_cross_correlation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.voxel  (voxel_ch),
		.result (result_ch)
	);

	corr_result_t         expected_corr [$];
	voxel_note_t          voxel_notes [$];
	logic [CROSS_W-1:0]   acc_cross;
	logic [ENERGY_W-1:0]  acc_energy_a;
	logic [ENERGY_W-1:0]  acc_energy_b;
	int                   failures;
	logic                 tx_burst;
	logic                 rx_burst;
	directed_row_t        directed_rows [ROWS];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic corr_result_t corr_from_sums(input logic [CROSS_W-1:0] cs,
		input logic [ENERGY_W-1:0] ea, input logic [ENERGY_W-1:0] eb);
		logic [191:0]       energy_prod;
		logic [191:0]       num;
		logic [191:0]       num4;
		logic [191:0]       trial;
		logic [191:0]       lhs;
		logic [CROSS_W-1:0] mag;
		logic [16:0]        q;
		logic               neg;
		corr_result_t       r;
		r.correlation = '0;
		r.zero_energy = 1'b1;
		if (ea == '0 || eb == '0) begin
			return r;
		end
		r.zero_energy = 1'b0;
		neg = cs[CROSS_W-1];
		mag = neg ? (~cs + 1'b1) : cs;
		energy_prod = 192'(ea) * 192'(eb);
		num = 192'(mag) * 192'(mag);
		num4 = num << 32;
		num = num << 30;
		q = '0;
		for (int i = 15; i >= 0; i--) begin
			trial = 192'(q | (17'd1 << i));
			lhs = trial * trial * energy_prod;
			if (lhs <= num) begin
				q = q | (17'd1 << i);
			end
		end
		if (q < 17'd32768) begin
			trial = 192'({q, 1'b1});
			lhs = trial * trial * energy_prod;
			if (lhs <= num4) begin
				q = q + 17'd1;
			end
		end else begin
			q = 17'd32768;
		end
		if (neg) begin
			r.correlation = 16'(17'h10000 - q);
		end else begin
			r.correlation = (q > 17'd32767) ? mncc_pkg::POS_MAX : q[15:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		logic signed [31:0] prod_ab;
		logic signed [31:0] sq_a;
		logic signed [31:0] sq_b;
		voxel_note_t        note;
		corr_result_t       want;
		if (arst_n) begin
			if (voxel_ch.valid && voxel_ch.ready) begin
				note = voxel_notes.pop_front();
				if (voxel_ch.in_mask) begin
					prod_ab = voxel_ch.sample_a * voxel_ch.sample_b;
					sq_a = voxel_ch.sample_a * voxel_ch.sample_a;
					sq_b = voxel_ch.sample_b * voxel_ch.sample_b;
					acc_cross = acc_cross + {{(CROSS_W-32){prod_ab[31]}}, prod_ab};
					acc_energy_a = acc_energy_a + {{(ENERGY_W-32){1'b0}}, sq_a};
					acc_energy_b = acc_energy_b + {{(ENERGY_W-32){1'b0}}, sq_b};
				end
				if (voxel_ch.last_voxel) begin
					want = note.typed ? note.want
						: corr_from_sums(acc_cross, acc_energy_a, acc_energy_b);
					expected_corr.push_back(want);
					acc_cross = '0;
					acc_energy_a = '0;
					acc_energy_b = '0;
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_corr.size() == 0) begin
					$error("result item with nothing expected: correlation %0d zero_energy %0d",
						result_ch.correlation, result_ch.zero_energy);
					failures++;
				end else begin
					want = expected_corr.pop_front();
					if (result_ch.correlation !== want.correlation) begin
						$error("correlation: expected %0d, actual %0d",
							want.correlation, result_ch.correlation);
						failures++;
					end
					if (result_ch.zero_energy !== want.zero_energy) begin
						$error("zero_energy: expected %0d, actual %0d",
							want.zero_energy, result_ch.zero_energy);
						failures++;
					end
				end
			end
		end
	end

	initial begin : receiver
		int stall;
		result_ch.ready <= 1'b0;
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	task automatic send_voxel(input voxel_t v, input logic typed, input corr_result_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			voxel_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		voxel_notes.push_back('{typed, want});
		voxel_ch.valid      <= 1'b1;
		voxel_ch.sample_a   <= v.sample_a;
		voxel_ch.sample_b   <= v.sample_b;
		voxel_ch.in_mask    <= v.in_mask;
		voxel_ch.last_voxel <= v.last_voxel;
		do @(posedge clk); while (!voxel_ch.ready);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		voxel_ch.valid <= 1'b0;
		while (expected_corr.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return -16'sd1;
			2: return 16'sd0;
			3: return 16'sd1;
			default: return 16'sh7fff;
		endcase
	endfunction

	initial begin : limit
		#8_000_000;
		$display("masked_normalized_cross_correlation_test failed");
		$finish;
	end

	initial begin : stimulus
		voxel_t        v;
		volume_style_t style;
		int            counted;
		int            len;
		int            mask_mode;
		int            noise;
		int            bits;
		logic          flip;
		corr_result_t  none;

		failures = 0;
		acc_cross = '0;
		acc_energy_a = '0;
		acc_energy_b = '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		none = '0;
		voxel_ch.valid      <= 1'b0;
		voxel_ch.sample_a   <= '0;
		voxel_ch.sample_b   <= '0;
		voxel_ch.in_mask    <= 1'b0;
		voxel_ch.last_voxel <= 1'b0;

		// sample_a, sample_b, in_mask, last_voxel | typed, correlation, zero_energy
		directed_rows = '{
			'{'{16'sd0,      16'sd0,      1'b0, 1'b1}, 1'b1, '{16'sd0,      1'b1}},
			'{'{16'sh7fff,   16'sh7fff,   1'b1, 1'b1}, 1'b1, '{16'sh7fff,   1'b0}},
			'{'{16'sh8000,   16'sh8000,   1'b1, 1'b1}, 1'b1, '{16'sh7fff,   1'b0}},
			'{'{16'sh8000,   16'sh7fff,   1'b1, 1'b1}, 1'b1, '{16'sh8000,   1'b0}},
			'{'{16'sh7fff,   16'sh8000,   1'b1, 1'b1}, 1'b1, '{16'sh8000,   1'b0}},
			'{'{16'sd0,      16'sd1234,   1'b1, 1'b1}, 1'b1, '{16'sd0,      1'b1}},
			'{'{-16'sd77,    16'sd0,      1'b1, 1'b1}, 1'b1, '{16'sd0,      1'b1}},
			'{'{16'sd500,    -16'sd600,   1'b0, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd9,      16'sd9,      1'b0, 1'b1}, 1'b1, '{16'sd0,      1'b1}},
			'{'{16'sd1,      16'sd1,      1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd1,      -16'sd1,     1'b1, 1'b1}, 1'b1, '{16'sd0,      1'b0}},
			'{'{16'sd100,    16'sd0,      1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd0,      16'sd100,    1'b1, 1'b1}, 1'b1, '{16'sd0,      1'b0}},
			'{'{16'sd3,      16'sd4,      1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{-16'sd5,     16'sd12,     1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sh7fff,   -16'sd1,     1'b0, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd7,      16'sd7,      1'b1, 1'b1}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd12345,  -16'sd23456, 1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{-16'sd1,     -16'sd1,     1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd20000,  16'sd20001,  1'b1, 1'b1}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd2,      16'sd2,      1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sd1000,   16'sd1000,   1'b0, 1'b1}, 1'b1, '{16'sh7fff,   1'b0}},
			'{'{16'sh8000,   16'sh7fff,   1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sh7fff,   16'sh8000,   1'b1, 1'b0}, 1'b0, '{16'sd0,      1'b0}},
			'{'{16'sh8000,   16'sh8000,   1'b1, 1'b1}, 1'b0, '{16'sd0,      1'b0}}
		};

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_voxel(directed_rows[i].voxel, directed_rows[i].typed, directed_rows[i].want);
		end
		hold_until_drained();

		counted = 0;
		while (counted < VOXEL_GOAL) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			style = volume_style_t'($urandom_range(0, 4));
			mask_mode = $urandom_range(0, 9);
			noise = $urandom_range(0, 2000);
			bits = $urandom_range(1, 15);
			flip = 1'($urandom_range(0, 1));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				hold_until_drained();
			end
			for (int k = 0; k < len; k++) begin
				case (style)
					STYLE_FULL: begin
						v.sample_a = 16'($urandom_range(0, 65535));
						v.sample_b = 16'($urandom_range(0, 65535));
					end
					STYLE_SMALL: begin
						v.sample_a = 16'($urandom_range(0, 100)) - 16'sd50;
						v.sample_b = 16'($urandom_range(0, 100)) - 16'sd50;
					end
					STYLE_NOISY: begin
						v.sample_a = 16'($urandom_range(0, 65535));
						v.sample_b = v.sample_a + 16'($urandom_range(0, 2 * noise)) - 16'(noise);
						if (flip) begin
							v.sample_b = -v.sample_b;
						end
					end
					STYLE_MIRROR: begin
						v.sample_a = 16'($urandom_range(0, 65535)) >>> (16 - bits);
						v.sample_b = flip ? -v.sample_a : v.sample_a;
					end
					default: begin
						v.sample_a = pick_extreme();
						v.sample_b = pick_extreme();
					end
				endcase
				case (mask_mode)
					0:       v.in_mask = 1'b0;
					1, 2:    v.in_mask = 1'($urandom_range(0, 1));
					default: v.in_mask = 1'b1;
				endcase
				v.last_voxel = (k == len - 1);
				if (v.last_voxel && $urandom_range(0, 3) == 0) begin
					v.in_mask = ~v.in_mask;
				end
				send_voxel(v, 1'b0, none);
				counted++;
			end
		end

		hold_until_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (failures == 0) begin
			$display("masked_normalized_cross_correlation_test passed");
		end else begin
			$display("masked_normalized_cross_correlation_test failed");
		end
		$finish;
	end

endmodule
